// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
   localparam logic [7:0]  CH_RETURN   = 8'h0D;
   localparam logic [7:0]  CH_BLANK    = 8'h20;
   localparam logic [15:0] RESET_BLANK = 16'h0720;

   localparam logic [3:0] FG_RESET = 4'd7;
   localparam logic [3:0] BG_RESET = 4'd0;

   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_CLEAR = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [0:0] CSR_FG = 1'b0;
   localparam logic [0:0] CSR_BG = 1'b1;

   typedef enum logic [2:0] {
      OP_GLYPH,
      OP_NEWLINE,
      OP_RETURN,
      OP_CLEAR,
      OP_READ,
      OP_NONE
   } tcw_op_type;

   typedef struct packed {
      tcw_op_type  op;
      logic [7:0]  glyph;
      logic [10:0] cell_index;
      logic        in_range;
   } tcw_cmd_type;

   typedef struct packed {
      logic [4:0]  cursor_row;
      logic [6:0]  cursor_col;
      logic [10:0] cursor_position;
      logic [15:0] cell_data;
      logic        scrolled;
   } tcw_rsp_type;

endpackage

// ===== rtl/tcw_fifo.sv =====
// ----------------------------------------------------------------------------
// tcw_fifo
// Small register queue with full/valid flags.
// ----------------------------------------------------------------------------
module tcw_fifo
   import tcw_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             valid
);

   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNTW'(DEPTH));
   assign valid   = (count_ff != '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/tcw_front.sv =====
// ----------------------------------------------------------------------------
// tcw_front
// Request decode: sorts each beat into a console command.
// ----------------------------------------------------------------------------
module tcw_front
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output tcw_cmd_type cmd
);

   localparam int CELLS = ROWS * COLUMNS;

   always_comb begin
      cmd.glyph      = req_char_code;
      cmd.cell_index = req_cell_index;
      cmd.in_range   = (32'(req_cell_index) < CELLS);
      unique case (req_type)
         REQ_PUT: begin
            if (req_char_code == CH_NEWLINE) begin
               cmd.op = OP_NEWLINE;
            end else if (req_char_code == CH_RETURN) begin
               cmd.op = OP_RETURN;
            end else begin
               cmd.op = OP_GLYPH;
            end
         end
         REQ_CLEAR: cmd.op = OP_CLEAR;
         REQ_READ:  cmd.op = OP_READ;
         default:   cmd.op = OP_NONE;
      endcase
   end

endmodule

// ===== rtl/tcw_back.sv =====
// ----------------------------------------------------------------------------
// tcw_back
// Command engine: cursor, screen store and the fill/scroll sweeps.
// ----------------------------------------------------------------------------
module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  attr,
   input  tcw_cmd_type cmd,
   input  logic        cmd_valid,
   output logic        cmd_pop,
   output tcw_rsp_type rsp,
   output logic        rsp_push,
   input  logic        rsp_full,
   output logic        initialising
);

   localparam int CELLS     = ROWS * COLUMNS;
   localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
   localparam int AW        = $clog2(CELLS);
   localparam int RW        = $clog2(ROWS);
   localparam int CW        = $clog2(COLUMNS);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_FILL,
      ST_SCROLL_PRIME,
      ST_SCROLL,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   state_type   state_ff, state_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] col_ff, col_in;
   logic [AW-1:0] wa_ff, wa_in;
   logic [15:0] fill_word_ff, fill_word_in;
   logic [15:0] data_ff, data_in;
   logic        scrolled_ff, scrolled_in;

   logic [15:0] store_mem [CELLS];
   logic [15:0] mem_rdata_ff;
   logic        mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [15:0] mem_wdata;

   logic [31:0] pos_full;
   logic [AW:0] rd_next;
   logic [15:0] blank_word;
   logic        last_cell, on_last_row, on_last_col, go_scroll;

   assign pos_full     = 32'(row_ff) * COLUMNS + 32'(col_ff);
   assign rd_next      = {1'b0, wa_ff} + (AW + 1)'(COLUMNS + 1);
   assign blank_word   = {attr, CH_BLANK};
   assign last_cell    = (wa_ff == AW'(CELLS - 1));
   assign on_last_row  = (row_ff == RW'(ROWS - 1));
   assign on_last_col  = (col_ff == CW'(COLUMNS - 1));
   assign initialising = (state_ff == ST_INIT);

   assign rsp.cursor_row      = 5'(row_ff);
   assign rsp.cursor_col      = 7'(col_ff);
   assign rsp.cursor_position = pos_full[10:0];
   assign rsp.cell_data       = data_ff;
   assign rsp.scrolled        = scrolled_ff;

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      wa_in        = wa_ff;
      fill_word_in = fill_word_ff;
      data_in      = data_ff;
      scrolled_in  = scrolled_ff;
      cmd_pop      = 1'b0;
      rsp_push     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = wa_ff;
      mem_wdata    = fill_word_ff;
      mem_re       = 1'b0;
      mem_raddr    = rd_next[AW-1:0];
      go_scroll    = 1'b0;

      unique case (state_ff)
         ST_INIT: begin
            mem_we    = 1'b1;
            mem_wdata = RESET_BLANK;
            if (last_cell) begin
               wa_in    = '0;
               state_in = ST_IDLE;
            end else begin
               wa_in = wa_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop     = 1'b1;
               data_in     = '0;
               scrolled_in = 1'b0;
               state_in    = ST_RESP;
               unique case (cmd.op)
                  OP_GLYPH: begin
                     mem_we    = 1'b1;
                     mem_waddr = pos_full[AW-1:0];
                     mem_wdata = {attr, cmd.glyph};
                     if (on_last_col) begin
                        col_in = '0;
                        if (on_last_row) begin
                           go_scroll = 1'b1;
                        end else begin
                           row_in = row_ff + 1'b1;
                        end
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  OP_NEWLINE: begin
                     col_in = '0;
                     if (on_last_row) begin
                        go_scroll = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  OP_RETURN: col_in = '0;
                  OP_CLEAR: begin
                     row_in       = '0;
                     col_in       = '0;
                     wa_in        = '0;
                     fill_word_in = blank_word;
                     state_in     = ST_FILL;
                  end
                  OP_READ: begin
                     if (cmd.in_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(cmd.cell_index);
                        state_in  = ST_READ_WAIT;
                     end
                  end
                  default: ;
               endcase
               if (go_scroll) begin
                  scrolled_in  = 1'b1;
                  fill_word_in = blank_word;
                  state_in     = ST_SCROLL_PRIME;
               end
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (last_cell) begin
               state_in = ST_RESP;
            end else begin
               wa_in = wa_ff + 1'b1;
            end
         end
         ST_SCROLL_PRIME: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(COLUMNS);
            wa_in     = '0;
            state_in  = ST_SCROLL;
         end
         ST_SCROLL: begin
            // write row r from the cell of row r+1 fetched last cycle; the last row is blanked
            mem_we    = 1'b1;
            mem_wdata = (wa_ff < AW'(LAST_BASE)) ? mem_rdata_ff : fill_word_ff;
            mem_re    = (rd_next < (AW + 1)'(CELLS));
            if (last_cell) begin
               state_in = ST_RESP;
            end else begin
               wa_in = wa_ff + 1'b1;
            end
         end
         ST_READ_WAIT: begin
            data_in  = mem_rdata_ff;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      fill_word_ff <= fill_word_in;
      data_ff      <= data_in;
      scrolled_ff  <= scrolled_in;
      if (reset) begin
         state_ff <= ST_INIT;
         row_ff   <= '0;
         col_ff   <= '0;
         wa_ff    <= '0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         wa_ff    <= wa_in;
      end
   end

endmodule

// ===== rtl/text_console_writer_core.sv =====
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text console engine: screen store of ROWS x COLUMNS cells and a cursor.
// ----------------------------------------------------------------------------
// Requests go in through a queue port (push/full), one result beat per
// request comes out through a queue port (empty/pop). Colours are set by
// csr writes, which the user must make while the engine is idle (unenforced).
// Requests are decoded into a two-entry command queue; the engine takes one
// command at a time and posts its result into a two-entry result queue, so
// a stalled receiver only halts the engine once that queue is full.
// Engine states per request; sweeps write one store cell per cycle:
//   put character, newline, carriage return, unused type: IDLE, RESP
//   read: IDLE, READ_WAIT, RESP (READ_WAIT skipped past the last cell)
//   clear: IDLE, FILL (over every cell), RESP
//   any scroll: IDLE, SCROLL_PRIME, SCROLL (copy, blank in one sweep), RESP
// A put-character result passes the command queue, the IDLE and RESP
// states and the result queue. After reset, full stays high while the
// ROWS*COLUMNS store cells are swept to blanks with attribute 0x07;
// csr writes are taken during that time.
// ----------------------------------------------------------------------------
module text_console_writer_core
   import tcw_pkg::*;
#(
   parameter int COLUMNS = COLUMNS_DEF,
   parameter int ROWS    = ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_type,
   input  logic [7:0]  req_char_code,
   input  logic [10:0] req_cell_index,
   output logic        empty,
   input  logic        pop,
   output logic [4:0]  rsp_cursor_row,
   output logic [6:0]  rsp_cursor_col,
   output logic [10:0] rsp_cursor_position,
   output logic [15:0] rsp_cell_data,
   output logic        rsp_scrolled,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_wdata
);

   logic [3:0]  fg_ff, bg_ff;
   tcw_cmd_type req_cmd, cmd;
   tcw_rsp_type rsp_in, rsp_out;
   logic        cmd_full, cmd_valid, cmd_pop;
   logic        rsp_push, rsp_full, rsp_valid;
   logic        initialising;

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= FG_RESET;
         bg_ff <= BG_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FG: fg_ff <= csr_wdata;
            CSR_BG: bg_ff <= csr_wdata;
         endcase
      end
   end

   tcw_front #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_front (
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_cell_index (req_cell_index),
      .cmd            (req_cmd)
   );

   tcw_fifo #(
      .WIDTH ($bits(tcw_cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push & ~initialising),
      .wdata (req_cmd),
      .full  (cmd_full),
      .pop   (cmd_pop),
      .rdata (cmd),
      .valid (cmd_valid)
   );

   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .attr         ({bg_ff, fg_ff}),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid),
      .cmd_pop      (cmd_pop),
      .rsp          (rsp_in),
      .rsp_push     (rsp_push),
      .rsp_full     (rsp_full),
      .initialising (initialising)
   );

   tcw_fifo #(
      .WIDTH ($bits(tcw_rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_in),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_out),
      .valid (rsp_valid)
   );

   assign full                = cmd_full | initialising;
   assign empty               = ~rsp_valid;
   assign rsp_cursor_row      = rsp_out.cursor_row;
   assign rsp_cursor_col      = rsp_out.cursor_col;
   assign rsp_cursor_position = rsp_out.cursor_position;
   assign rsp_cell_data       = rsp_out.cell_data;
   assign rsp_scrolled        = rsp_out.scrolled;

   a_reset_empty : assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty after reset");

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result beat posted into a full queue");

   a_init_quiet : assert property (@(posedge clock) disable iff (reset)
      initialising |-> !rsp_push && !cmd_pop)
      else $error("engine active during store sweep");

   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty queue");

endmodule
